/* sv/tamav_pkg.sv */
// Shared types, constants and width helpers for the trimmed-mean and
// moving-average filter. No dependencies.
package tamav_pkg;

    localparam int SAMPLE_W         = 12;
    localparam int FRAME_LEN        = 20;
    localparam int FRAME_SKIP       = 2;
    localparam int TRIM_SHIFT       = 4;
    localparam int SUM_W            = 17;
    localparam int POS_W            = 5;
    localparam int WINDOW_DEPTH_DEF = 20;
    localparam int BLOCK_LENGTH_DEF = 10;

    typedef enum logic {
        KIND_TEMP = 1'b0,
        KIND_ADJ  = 1'b1
    } kind_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } item_tag_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] maxv;
        logic [SAMPLE_W-1:0] minv;
    } trim_t;

    // Width of the value carried between stages: frame sum, window total
    // or block total, whichever is widest.
    function automatic int data_width(input int depth, input int blen);
        int w;
        w = SUM_W;
        if (SAMPLE_W + $clog2(depth) > w) w = SAMPLE_W + $clog2(depth);
        if (SAMPLE_W + $clog2(blen) > w) w = SAMPLE_W + $clog2(blen);
        return w;
    endfunction

endpackage

/* sv/tamav_front.sv */
// Input stage: frame sum/max/min tracking for temperature items and block
// totals for adjust items. Depends on tamav_pkg.
module tamav_front import tamav_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int BLOCK_LENGTH = BLOCK_LENGTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_channel,
    input  logic [SAMPLE_W-1:0] s_sample,
    output item_tag_t           f_tag,
    input  logic                f_ready,
    output logic [data_width(WINDOW_DEPTH, BLOCK_LENGTH)-1:0] f_sum,
    output trim_t               f_trim
);

    localparam int DATA_W = data_width(WINDOW_DEPTH, BLOCK_LENGTH);
    localparam int BPOS_W = $clog2(BLOCK_LENGTH);
    localparam int BT_W   = SAMPLE_W + $clog2(BLOCK_LENGTH);

    logic [POS_W-1:0]    frame_pos_reg;
    logic [SUM_W-1:0]    frame_sum_reg;
    logic [SAMPLE_W-1:0] frame_max_reg;
    logic [SAMPLE_W-1:0] frame_min_reg;
    logic [BPOS_W-1:0]   blk_pos_reg;
    logic [BT_W-1:0]     blk_tot_reg;
    item_tag_t           s1_tag_reg;
    logic [DATA_W-1:0]   s1_sum_reg;
    trim_t               s1_trim_reg;

    logic                accept;
    logic                is_adj;
    logic                first_kept;
    logic                kept;
    logic                frame_end;
    logic                blk_end;
    logic                emit;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] max_next;
    logic [SAMPLE_W-1:0] min_next;
    logic [BT_W-1:0]     blk_next;

    assign s_ready    = !s1_tag_reg.valid || f_ready;
    assign accept     = s_valid && s_ready;
    assign is_adj     = (kind_t'(s_channel) == KIND_ADJ);
    assign first_kept = (frame_pos_reg == POS_W'(FRAME_SKIP));
    assign kept       = (frame_pos_reg >= POS_W'(FRAME_SKIP));
    assign frame_end  = (frame_pos_reg == POS_W'(FRAME_LEN - 1));
    assign blk_end    = (blk_pos_reg == BPOS_W'(BLOCK_LENGTH - 1));
    assign emit       = accept && (is_adj ? blk_end : frame_end);

    // First kept sample of a frame restarts sum, max and min.
    assign sum_next = (first_kept ? '0 : frame_sum_reg) + SUM_W'(s_sample);
    assign max_next = (first_kept || s_sample > frame_max_reg) ? s_sample : frame_max_reg;
    assign min_next = (first_kept || s_sample < frame_min_reg) ? s_sample : frame_min_reg;
    assign blk_next = ((blk_pos_reg == '0) ? '0 : blk_tot_reg) + BT_W'(s_sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_pos_reg <= '0;
            blk_pos_reg   <= '0;
            s1_tag_reg    <= '0;
        end else begin
            if (accept && !is_adj) begin
                frame_pos_reg <= frame_end ? '0 : frame_pos_reg + POS_W'(1);
            end
            if (accept && is_adj) begin
                blk_pos_reg <= blk_end ? '0 : blk_pos_reg + BPOS_W'(1);
            end
            if (s_ready) begin
                s1_tag_reg.valid <= emit;
                s1_tag_reg.kind  <= kind_t'(s_channel);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !is_adj && kept) begin
            frame_sum_reg <= sum_next;
            frame_max_reg <= max_next;
            frame_min_reg <= min_next;
        end
        if (accept && is_adj) begin
            blk_tot_reg <= blk_next;
        end
        if (emit) begin
            s1_sum_reg       <= is_adj ? DATA_W'(blk_next) : DATA_W'(sum_next);
            s1_trim_reg.maxv <= max_next;
            s1_trim_reg.minv <= min_next;
        end
    end

    assign f_tag  = s1_tag_reg;
    assign f_sum  = s1_sum_reg;
    assign f_trim = s1_trim_reg;

endmodule

/* sv/tamav_ring.sv */
// Trim stage and moving-average ring: the ring entries live in a
// synchronous memory, the running total in a register. Depends on tamav_pkg.
module tamav_ring import tamav_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int BLOCK_LENGTH = BLOCK_LENGTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  item_tag_t f_tag,
    output logic      f_ready,
    input  logic [data_width(WINDOW_DEPTH, BLOCK_LENGTH)-1:0] f_sum,
    input  trim_t     f_trim,
    output item_tag_t r_tag,
    input  logic      r_ready,
    output logic [data_width(WINDOW_DEPTH, BLOCK_LENGTH)-1:0] r_val
);

    localparam int DATA_W = data_width(WINDOW_DEPTH, BLOCK_LENGTH);
    localparam int PTR_W  = $clog2(WINDOW_DEPTH);
    localparam int TOT_W  = SAMPLE_W + $clog2(WINDOW_DEPTH);

    logic [SAMPLE_W-1:0] win_mem [WINDOW_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_ok_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic                primed_reg;
    logic                first_lap_reg;
    logic [SAMPLE_W-1:0] first_val_reg;
    logic [TOT_W-1:0]    total_reg;
    item_tag_t           s2_tag_reg;
    logic [DATA_W-1:0]   s2_val_reg;
    item_tag_t           s3_tag_reg;
    logic [DATA_W-1:0]   s3_val_reg;

    logic [SUM_W-1:0]    diff;
    logic [SAMPLE_W-1:0] trimmed;
    logic                s2_temp;
    logic                hold;
    logic                s3_en;
    logic                take;
    logic                s2_en;
    logic                win_wr;
    logic                wrap;
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] old;
    logic [TOT_W-1:0]    total_next;

    assign diff    = f_sum[SUM_W-1:0] - SUM_W'(f_trim.maxv) - SUM_W'(f_trim.minv);
    assign trimmed = diff[TRIM_SHIFT +: SAMPLE_W];

    // The memory read of the new slot is registered and lands in the cycle after
    // a ring write; hold a following frame result until then.
    assign s2_temp = s2_tag_reg.valid && (s2_tag_reg.kind == KIND_TEMP);
    assign hold    = s2_temp && !rd_ok_reg;
    assign s3_en   = !s3_tag_reg.valid || r_ready;
    assign take    = s3_en && !hold;
    assign s2_en   = !s2_tag_reg.valid || take;
    assign f_ready = s2_en;
    assign win_wr  = take && s2_temp;
    assign wrap    = (ptr_reg == PTR_W'(WINDOW_DEPTH - 1));

    assign v   = s2_val_reg[SAMPLE_W-1:0];
    // Slots not yet overwritten since priming read as the first value.
    assign old = first_lap_reg ? first_val_reg : rd_data_reg;
    assign total_next = primed_reg ? total_reg - TOT_W'(old) + TOT_W'(v)
                                   : TOT_W'(v) * TOT_W'(WINDOW_DEPTH);

    always_ff @(posedge aclk) begin
        if (win_wr) begin
            win_mem[ptr_reg] <= v;
        end
        rd_data_reg <= win_mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ok_reg     <= 1'b0;
            ptr_reg       <= '0;
            primed_reg    <= 1'b0;
            first_lap_reg <= 1'b0;
            s2_tag_reg    <= '0;
            s3_tag_reg    <= '0;
        end else begin
            rd_ok_reg <= !win_wr;
            if (win_wr) begin
                ptr_reg    <= wrap ? '0 : ptr_reg + PTR_W'(1);
                primed_reg <= 1'b1;
                if (!primed_reg) begin
                    first_lap_reg <= 1'b1;
                end else if (wrap) begin
                    first_lap_reg <= 1'b0;
                end
            end
            if (s2_en) begin
                s2_tag_reg <= f_tag;
            end
            if (s3_en) begin
                s3_tag_reg.valid <= s2_tag_reg.valid && !hold;
                s3_tag_reg.kind  <= s2_tag_reg.kind;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (win_wr) begin
            total_reg <= total_next;
            if (!primed_reg) begin
                first_val_reg <= v;
            end
        end
        if (s2_en && f_tag.valid) begin
            s2_val_reg <= (f_tag.kind == KIND_ADJ) ? f_sum : DATA_W'(trimmed);
        end
        if (take && s2_tag_reg.valid) begin
            s3_val_reg <= s2_temp ? DATA_W'(total_next) : s2_val_reg;
        end
    end

    assign r_tag = s3_tag_reg;
    assign r_val = s3_val_reg;

endmodule

/* sv/tamav_div.sv */
// Constant division of window and block totals by reciprocal multiply,
// plus the output register. Depends on tamav_pkg.
module tamav_div import tamav_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int BLOCK_LENGTH = BLOCK_LENGTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  item_tag_t           r_tag,
    output logic                r_ready,
    input  logic [data_width(WINDOW_DEPTH, BLOCK_LENGTH)-1:0] r_val,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_result_kind,
    output logic [SAMPLE_W-1:0] m_filtered_value
);

    localparam int DATA_W = data_width(WINDOW_DEPTH, BLOCK_LENGTH);
    localparam int WIN_N  = SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int WIN_SH = WIN_N + $clog2(WINDOW_DEPTH);
    localparam int BLK_N  = SAMPLE_W + $clog2(BLOCK_LENGTH);
    localparam int BLK_SH = BLK_N + $clog2(BLOCK_LENGTH);
    localparam int RCP_W  = DATA_W + 2;
    localparam int PROD_W = DATA_W + RCP_W;
    // ceil(2^SH / D) gives an exact floor quotient for every total in range
    localparam logic [63:0] WIN_RCP =
        ((64'd1 << WIN_SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [63:0] BLK_RCP =
        ((64'd1 << BLK_SH) + 64'(BLOCK_LENGTH) - 64'd1) / 64'(BLOCK_LENGTH);

    item_tag_t           s4_tag_reg;
    logic [PROD_W-1:0]   s4_prod_reg;
    logic                m_valid_reg;
    logic                m_kind_reg;
    logic [SAMPLE_W-1:0] m_value_reg;

    logic                out_en;
    logic                s4_en;
    logic [RCP_W-1:0]    rcp;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   quot;

    assign out_en  = !m_valid_reg || m_ready;
    assign s4_en   = !s4_tag_reg.valid || out_en;
    assign r_ready = s4_en;

    assign rcp  = (r_tag.kind == KIND_ADJ) ? BLK_RCP[RCP_W-1:0] : WIN_RCP[RCP_W-1:0];
    assign prod = PROD_W'(r_val) * PROD_W'(rcp);
    assign quot = (s4_tag_reg.kind == KIND_ADJ) ? (s4_prod_reg >> BLK_SH)
                                                : (s4_prod_reg >> WIN_SH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_tag_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s4_en) begin
                s4_tag_reg <= r_tag;
            end
            if (out_en) begin
                m_valid_reg <= s4_tag_reg.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s4_en && r_tag.valid) begin
            s4_prod_reg <= prod;
        end
        if (out_en && s4_tag_reg.valid) begin
            m_kind_reg  <= s4_tag_reg.kind;
            m_value_reg <= quot[SAMPLE_W-1:0];
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = m_kind_reg;
    assign m_filtered_value = m_value_reg;

endmodule

/* sv/adc_trimmed_and_moving_average.sv */
// Top level of the trimmed-mean and moving-average filter.
// Depends on tamav_pkg, tamav_front, tamav_ring and tamav_div.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   s_      | in        | s_valid / s_ready  | s_channel, s_sample[11:0]
//   m_      | out       | m_valid / m_ready  | m_result_kind, m_filtered_value[11:0]
//
// One item per cycle in while s_ready is high; a result for the item that
// completes a frame or block leaves through a five-register pipeline.
// The ring memory read is registered: a frame result that directly
// follows another into the ring update stage waits for the new slot's read.
// Reset is synchronous on aresetn; the ring needs no clearing pass, since
// the first trimmed value stands in for every slot not yet written.
// Each stage holds while the next is full and stalled or, in the ring update
// stage, waits for that read; s_ready drops only when results back up to the input register.
module adc_trimmed_and_moving_average import tamav_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
    parameter int BLOCK_LENGTH = BLOCK_LENGTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_channel,
    input  logic [SAMPLE_W-1:0] s_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_result_kind,
    output logic [SAMPLE_W-1:0] m_filtered_value
);

    localparam int DATA_W = data_width(WINDOW_DEPTH, BLOCK_LENGTH);

    item_tag_t         f_tag;
    logic              f_ready;
    logic [DATA_W-1:0] f_sum;
    trim_t             f_trim;
    item_tag_t         r_tag;
    logic              r_ready;
    logic [DATA_W-1:0] r_val;

    tamav_front #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .BLOCK_LENGTH(BLOCK_LENGTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_channel (s_channel),
        .s_sample  (s_sample),
        .f_tag     (f_tag),
        .f_ready   (f_ready),
        .f_sum     (f_sum),
        .f_trim    (f_trim)
    );

    tamav_ring #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .BLOCK_LENGTH(BLOCK_LENGTH)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .f_tag   (f_tag),
        .f_ready (f_ready),
        .f_sum   (f_sum),
        .f_trim  (f_trim),
        .r_tag   (r_tag),
        .r_ready (r_ready),
        .r_val   (r_val)
    );

    tamav_div #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .BLOCK_LENGTH(BLOCK_LENGTH)
    ) u_div (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .r_tag            (r_tag),
        .r_ready          (r_ready),
        .r_val            (r_val),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_filtered_value (m_filtered_value)
    );

endmodule

/* sv/tamav_chk.sv */
// Port-level checks for the filter top level, attached by bind.
// Depends on tamav_pkg and adc_trimmed_and_moving_average.
module tamav_chk import tamav_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic                m_result_kind,
    input logic [SAMPLE_W-1:0] m_filtered_value
);

    // Pipeline empties on reset: no result shown right after it.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Empty pipeline takes an item at once after reset.
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_kind)
                                && $stable(m_filtered_value))
        else $error("stalled result changed or dropped");

endmodule

bind adc_trimmed_and_moving_average tamav_chk u_tamav_chk (.*);

/* bench/adc_trimmed_and_moving_average_test.sv */
// Self-checking bench for adc_trimmed_and_moving_average: a scoreboard class
// predicts filtered values, and random idles stress both handshakes.
// Depends on tamav_pkg and the RTL top level only.

module adc_trimmed_and_moving_average_test import tamav_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1320;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 12;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        kind_t               kind;
        logic [SAMPLE_W-1:0] value;
    } filtered_t;

    typedef enum int {
        SPREAD_FULL,
        SPREAD_LOW,
        SPREAD_HIGH,
        SPREAD_EDGES,
        SPREAD_NARROW
    } spread_t;

    // Tracks the filter state and holds the results still owed by the block.
    class filter_scoreboard;
        bit [POS_W-1:0]    frame_pos;
        bit [SUM_W-1:0]    frame_acc;
        bit [SAMPLE_W-1:0] frame_hi;
        bit [15:0]         frame_lo;
        bit [SAMPLE_W-1:0] ring [WINDOW_DEPTH_DEF];
        int unsigned       ring_ptr;
        bit                ring_filled;
        bit [SUM_W-1:0]    ring_sum;
        bit [3:0]          blk_pos;
        bit [15:0]         blk_acc;
        filtered_t         awaited[$];
        int                mismatches;

        function new();
            clear_frame();
            foreach (ring[k]) ring[k] = '0;
            ring_ptr    = 0;
            ring_filled = 1'b0;
            ring_sum    = '0;
            blk_pos     = '0;
            blk_acc     = '0;
            mismatches  = 0;
        endfunction

        function void clear_frame();
            frame_pos = '0;
            frame_acc = '0;
            frame_hi  = '0;
            frame_lo  = 16'hFFFF;
        endfunction

        function void note_sample(input kind_t chan, input logic [SAMPLE_W-1:0] smp);
            bit [31:0]         trim_diff;
            bit [SAMPLE_W-1:0] trimmed;
            filtered_t         owed;
            if (chan == KIND_TEMP) begin
                // drop the settling samples at the head of each frame
                if (frame_pos >= FRAME_SKIP) begin
                    if (smp > frame_hi) frame_hi = smp;
                    if (smp < frame_lo) frame_lo = smp;
                    frame_acc = frame_acc + smp;
                end
                frame_pos = frame_pos + 1'b1;
                if (frame_pos >= FRAME_LEN) begin
                    trim_diff = 32'(frame_acc) - 32'(frame_hi) - 32'(frame_lo);
                    trimmed   = trim_diff[TRIM_SHIFT +: SAMPLE_W];
                    // first trimmed value stands in for every ring slot
                    if (!ring_filled) begin
                        foreach (ring[k]) ring[k] = trimmed;
                        ring_sum    = SUM_W'(32'(trimmed) * WINDOW_DEPTH_DEF);
                        ring_filled = 1'b1;
                    end
                    ring_sum       = ring_sum - ring[ring_ptr] + trimmed;
                    ring[ring_ptr] = trimmed;
                    ring_ptr       = (ring_ptr + 1) % WINDOW_DEPTH_DEF;
                    owed.kind      = KIND_TEMP;
                    owed.value     = SAMPLE_W'(ring_sum / WINDOW_DEPTH_DEF);
                    awaited.push_back(owed);
                    clear_frame();
                end
            end else begin
                blk_acc = blk_acc + smp;
                blk_pos = blk_pos + 1'b1;
                if (blk_pos >= BLOCK_LENGTH_DEF) begin
                    owed.kind  = KIND_ADJ;
                    owed.value = SAMPLE_W'(blk_acc / BLOCK_LENGTH_DEF);
                    awaited.push_back(owed);
                    blk_pos = '0;
                    blk_acc = '0;
                end
            end
        endfunction

        function void check_result(input kind_t kind, input logic [SAMPLE_W-1:0] value);
            filtered_t owed;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected result kind=%0d value=%0d",
                             $time, kind, value);
            end else begin
                owed = awaited.pop_front();
                if (kind !== owed.kind || value !== owed.value) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: mismatch: expected kind=%0d value=%0d, got kind=%0d value=%0d",
                                 $time, owed.kind, owed.value, kind, value);
                end
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_channel = 1'b0;
    logic [SAMPLE_W-1:0] s_sample = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_result_kind;
    logic [SAMPLE_W-1:0] m_filtered_value;

    filter_scoreboard board;
    bit               steady = 1'b0;
    int unsigned      rx_hold = 0;
    int unsigned      rx_roll;
    int unsigned      idle_cycles = 0;

    adc_trimmed_and_moving_average u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_channel        (s_channel),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_filtered_value (m_filtered_value)
    );

    always #2 aclk = ~aclk;

    // Receiver: mostly ready, with short and occasional long stalls.
    always @(negedge aclk) begin
        if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= 1'b1;
            rx_roll = $urandom_range(0, 99);
            if (!steady && rx_roll < 20)
                rx_hold <= $urandom_range(1, 3);
            else if (!steady && rx_roll < 23)
                rx_hold <= $urandom_range(10, 40);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(kind_t'(m_result_kind), m_filtered_value);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input spread_t spread);
        case (spread)
            SPREAD_LOW:    return SAMPLE_W'($urandom_range(0, 15));
            SPREAD_HIGH:   return SAMPLE_W'($urandom_range(4080, 4095));
            SPREAD_EDGES:  return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
            SPREAD_NARROW: return SAMPLE_W'($urandom_range(2000, 2100));
            default:       return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic chan, input logic [SAMPLE_W-1:0] smp);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_channel <= chan;
        s_sample  <= smp;
        s_valid   <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_sample(kind_t'(chan), smp);
        @(negedge aclk);
    endtask

    task automatic run_random(input int count);
        spread_t     spread;
        int unsigned run_len;
        int unsigned temp_pct;
        int unsigned k;
        logic        chan;
        while (count > 0) begin
            run_len  = $urandom_range(1, 40);
            spread   = spread_t'($urandom_range(0, 4));
            temp_pct = ($urandom_range(0, 3) == 0) ? 30 : 75;
            steady   = ($urandom_range(0, 4) == 0);
            for (k = 0; k < run_len && count > 0; k++) begin
                chan = ($urandom_range(0, 99) < temp_pct) ? KIND_TEMP : KIND_ADJ;
                send_item(chan, pick_sample(spread));
                count--;
            end
        end
    endtask

    initial begin
        int i;
        logic [SAMPLE_W-1:0] smp;
        board = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // One full frame that primes the ring, with an all-max adjust block
        // woven in. Full-scale head samples must be dropped from the trim.
        for (i = 0; i < FRAME_LEN; i++) begin
            if (i < FRAME_SKIP) smp = 12'hFFF;
            else if (i == FRAME_SKIP) smp = 12'h000;
            else if (i == FRAME_SKIP + 1) smp = 12'hFFF;
            else smp = SAMPLE_W'(i * 200 + 7);
            send_item(KIND_TEMP, smp);
            if (i % 2 == 1) send_item(KIND_ADJ, 12'hFFF);
        end

        run_random(RANDOM_ITEMS);
        s_valid <= 1'b0;
        steady  = 1'b0;

        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (board.mismatches == 0 && board.awaited.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
sv/tamav_pkg.sv
sv/tamav_front.sv
sv/tamav_ring.sv
sv/tamav_div.sv
sv/adc_trimmed_and_moving_average.sv
sv/tamav_chk.sv
bench/adc_trimmed_and_moving_average_test.sv
